// File: rtl/speech_endpoint_detector_top_assert.svh
`ifndef SPEECH_ENDPOINT_DETECTOR_TOP_ASSERT_SVH
`define SPEECH_ENDPOINT_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define SED_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("endpoint detector check failed");

// next-cycle implication
`define SED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("endpoint detector check failed");

`endif

// File: rtl/sed_pkg.sv
package sed_pkg;

  localparam int unsigned BLOCK_MAX_DEF = 1024;
  localparam int unsigned BLOCK_MAX_W   = 17;

  localparam logic [15:0] THRESHOLD_RST     = 16'd1000;
  localparam logic [15:0] SILENCE_LIMIT_RST = 16'd1000;
  localparam logic [23:0] START_TIMEOUT_RST = 24'd80000;
  localparam logic [23:0] TOTAL_SAMPLES_RST = 24'd160000;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_BLOCK = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    REASON_NONE        = 2'd0,
    REASON_ALL_SAMPLES = 2'd1,
    REASON_SILENCE     = 2'd2,
    REASON_NO_SPEECH   = 2'd3
  } end_reason_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_THRESHOLD     = 2'd0,
    REG_SILENCE_LIMIT = 2'd1,
    REG_START_TIMEOUT = 2'd2,
    REG_TOTAL_SAMPLES = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] level_threshold;
    logic [15:0] silence_limit_ms;
    logic [23:0] start_timeout_samples;
    logic [23:0] total_samples;
  } sed_cfg_t;

  typedef struct packed {
    logic        turn_done;
    logic        started;
    logic        silent;
    logic        onset_marked;
    logic [31:0] silence_start_ms;
    logic [23:0] samples_done;
    logic [15:0] peak_level;
  } sed_state_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] block_mean;
    logic [10:0] block_samples;
    logic [31:0] now_ms;
    logic        cloud_voice;
  } sed_item_t;

  typedef struct packed {
    logic        is_last;
    end_reason_t end_reason;
    logic        loud;
    logic        talk_started;
    logic        voice_onset;
    logic [15:0] peak_mean;
    logic        ignored;
  } sed_result_t;

  // input tdata layout, lowest field last
  typedef struct packed {
    logic [3:0]  pad;
    logic        cloud_voice;
    logic [31:0] now_ms;
    logic [10:0] block_samples;
    logic [15:0] block_mean;
  } sed_in_data_t;

  // output tdata layout, lowest field last
  typedef struct packed {
    logic [1:0]  pad;
    logic        ignored;
    logic [15:0] peak_mean;
    logic        voice_onset;
    logic        talk_started;
    logic        loud;
    end_reason_t end_reason;
  } sed_out_data_t;

endpackage

// File: rtl/sed_cfg_regs.sv
module sed_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sed_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sed_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output sed_pkg::sed_cfg_t                  cfg
);
  import sed_pkg::*;

  sed_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_threshold       <= THRESHOLD_RST;
      cfg_r.silence_limit_ms      <= SILENCE_LIMIT_RST;
      cfg_r.start_timeout_samples <= START_TIMEOUT_RST;
      cfg_r.total_samples         <= TOTAL_SAMPLES_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_THRESHOLD:     cfg_r.level_threshold       <= cfg_wdata[15:0];
        REG_SILENCE_LIMIT: cfg_r.silence_limit_ms      <= cfg_wdata[15:0];
        REG_START_TIMEOUT: cfg_r.start_timeout_samples <= cfg_wdata;
        REG_TOTAL_SAMPLES: cfg_r.total_samples         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/sed_decide.sv
module sed_decide #(
  parameter int unsigned BLOCK_MAX = sed_pkg::BLOCK_MAX_DEF
) (
  input  sed_pkg::sed_cfg_t    cfg,
  input  sed_pkg::sed_state_t  st,
  input  sed_pkg::sed_item_t   item,
  output sed_pkg::sed_state_t  st_nxt,
  output sed_pkg::sed_result_t res
);
  import sed_pkg::*;

  localparam logic [BLOCK_MAX_W-1:0] BlockMaxW = BLOCK_MAX_W'(BLOCK_MAX);

  logic [10:0] count_blk;
  logic [23:0] count_24;
  logic [23:0] remaining;
  logic [23:0] count_c;
  logic [23:0] after;
  logic        loud;
  logic        all_taken;
  logic [31:0] silence_dur;

  // block size cap, then cap to what is still missing
  assign count_blk = (BLOCK_MAX_W'(item.block_samples) > BlockMaxW) ?
                     BlockMaxW[10:0] : item.block_samples;
  assign count_24  = {13'b0, count_blk};
  assign remaining = (st.samples_done < cfg.total_samples) ?
                     (cfg.total_samples - st.samples_done) : 24'd0;
  assign count_c   = (count_24 > remaining) ? remaining : count_24;
  assign after     = st.samples_done + count_c;
  assign all_taken = (after >= cfg.total_samples);
  assign loud      = (item.block_mean > cfg.level_threshold);
  // modulo 2^32 so a clock wrap is harmless
  assign silence_dur = item.now_ms - st.silence_start_ms;

  always_comb begin
    st_nxt = st;
    res    = '0;
    if (item.action == ACT_START) begin
      st_nxt = '0;
    end else if (st.turn_done) begin
      res.talk_started = st.started;
      res.peak_mean    = st.peak_level;
      res.ignored      = 1'b1;
    end else begin
      if (item.block_mean > st.peak_level) begin
        st_nxt.peak_level = item.block_mean;
      end
      if (item.cloud_voice && !st.started) begin
        st_nxt.started          = 1'b1;
        st_nxt.silent           = 1'b0;
        st_nxt.silence_start_ms = '0;
      end
      if (all_taken) begin
        res.is_last    = 1'b1;
        res.end_reason = REASON_ALL_SAMPLES;
      end
      if (loud) begin
        res.loud = 1'b1;
        if (!st.onset_marked) begin
          st_nxt.onset_marked = 1'b1;
          res.voice_onset     = 1'b1;
        end
        st_nxt.started          = 1'b1;
        st_nxt.silent           = 1'b0;
        st_nxt.silence_start_ms = '0;
      end else if (!st_nxt.silent) begin
        st_nxt.silent           = 1'b1;
        st_nxt.silence_start_ms = item.now_ms;
      end else if (st_nxt.started) begin
        if (silence_dur >= {16'b0, cfg.silence_limit_ms}) begin
          res.is_last = 1'b1;
          if (!all_taken) begin
            res.end_reason = REASON_SILENCE;
          end
        end
      end else if (after >= cfg.start_timeout_samples) begin
        res.is_last = 1'b1;
        if (!all_taken) begin
          res.end_reason = REASON_NO_SPEECH;
        end
      end
      st_nxt.samples_done = after;
      st_nxt.turn_done    = res.is_last;
      res.talk_started    = st_nxt.started;
      res.peak_mean       = st_nxt.peak_level;
    end
  end

endmodule

// File: rtl/speech_endpoint_detector_top.sv
// End-of-turn detector for one spoken turn. Each input item is either a
// start-turn command (tuser 0, clears all turn state) or one audio block
// (tuser 1) with its mean level, sample count, millisecond time and the
// recognizer's text flag; every item yields exactly one result item, with
// tlast set on the block that ends the turn and the end reason in tdata.
// Items are taken every cycle when the output side keeps up: an input
// register feeds a single decision stage that updates the turn state and
// loads the output register, so each item passes the input register and then
// the output register on its way out, and throughput is one item per clock.
// While out_tready stays low the output register and the input register
// each hold one item, and in_tready drops until the output drains; in_tready
// is also low during reset. Blocks arriving after the turn ended come back
// with the ignored flag set and change nothing.
// Configuration registers are written through cfg_* and must only be
// changed while no item is in flight.
module speech_endpoint_detector_top #(
  parameter int unsigned BLOCK_MAX = sed_pkg::BLOCK_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [15:0] block_mean, [26:16] block_samples, [58:27] now_ms, [59] cloud_voice
  input  logic [63:0]                    in_tdata,
  // [0] action
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [1:0] end_reason, [2] loud, [3] talk_started, [4] voice_onset,
  // [20:5] peak_mean, [21] ignored
  output logic [23:0]                    out_tdata,
  // is_last
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [sed_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sed_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sed_pkg::*;

  sed_cfg_t      cfg;
  sed_state_t    st_r;
  sed_state_t    st_nxt;
  sed_item_t     item_r;
  sed_result_t   res;
  sed_result_t   res_r;
  sed_in_data_t  in_data;
  sed_out_data_t out_data;
  logic          s1_valid_r;
  logic          out_valid_r;
  logic          adv;

  sed_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sed_decide #(
    .BLOCK_MAX (BLOCK_MAX)
  ) u_decide (
    .cfg    (cfg),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign in_data   = sed_in_data_t'(in_tdata);
  // decision stage moves when the output register is free or being drained
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!s1_valid_r || adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.action        <= action_t'(in_tuser);
      item_r.block_mean    <= in_data.block_mean;
      item_r.block_samples <= in_data.block_samples;
      item_r.now_ms        <= in_data.now_ms;
      item_r.cloud_voice   <= in_data.cloud_voice;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  always_comb begin
    out_data              = '0;
    out_data.end_reason   = res_r.end_reason;
    out_data.loud         = res_r.loud;
    out_data.talk_started = res_r.talk_started;
    out_data.voice_onset  = res_r.voice_onset;
    out_data.peak_mean    = res_r.peak_mean;
    out_data.ignored      = res_r.ignored;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data;
  assign out_tlast  = res_r.is_last;

endmodule

// File: rtl/sed_checker.sv
`include "speech_endpoint_detector_top_assert.svh"

module sed_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);
  import sed_pkg::*;

  sed_out_data_t od;

  assign od = sed_out_data_t'(out_tdata);

  // a last item always carries a reason, and a reason only comes with tlast
  `SED_ASSERT_NOW(a_last_has_reason, clk, rst_n, out_tvalid,
                  out_tlast == (od.end_reason != REASON_NONE))

  // an ignored block reports nothing but the held flags
  `SED_ASSERT_NOW(a_ignored_quiet, clk, rst_n, out_tvalid && od.ignored,
                  !out_tlast && !od.loud && !od.voice_onset)

  // onset only on a loud block, and it marks speech as started
  `SED_ASSERT_NOW(a_onset_loud, clk, rst_n, out_tvalid && od.voice_onset,
                  od.loud && od.talk_started)

  // input only backs up behind a stalled result
  `SED_ASSERT_NOW(a_in_stall_cause, clk, rst_n, !in_tready,
                  out_tvalid && !out_tready)

  // a stalled result holds
  `SED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind speech_endpoint_detector_top sed_checker u_sed_checker (.*);

// File: dv/speech_endpoint_detector_top_tb.sv
`timescale 1ns / 100ps

module speech_endpoint_detector_top_tb;
  import sed_pkg::*;

  localparam int unsigned BLOCK_LIMIT = BLOCK_MAX_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 190;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    bit          is_cfg;
    reg_idx_t    idx;
    logic [23:0] val;
    sed_item_t   it;
    bit          lit;
    sed_result_t want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  speech_endpoint_detector_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // turn tracker copy, updated at each accepted item
  bit [15:0] thr_cfg = THRESHOLD_RST;
  bit [15:0] silence_cfg = SILENCE_LIMIT_RST;
  bit [23:0] start_cfg = START_TIMEOUT_RST;
  bit [23:0] total_cfg = TOTAL_SAMPLES_RST;
  bit        turn_over, spoke, quiet, onset_seen;
  bit [31:0] quiet_since;
  bit [23:0] recorded;
  bit [15:0] loudest;

  sed_result_t pending_results[$];
  step_t       plan[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  int          hold_asked = 0;
  int          hold_served = 0;

  function automatic sed_result_t predict_endpoint(input sed_item_t it);
    sed_result_t r;
    logic [23:0] take;
    logic [23:0] room;
    logic [23:0] filled;
    logic [31:0] quiet_ms;
    r = '0;
    if (it.action == ACT_START) begin
      turn_over = 1'b0;
      spoke = 1'b0;
      quiet = 1'b0;
      onset_seen = 1'b0;
      quiet_since = '0;
      recorded = '0;
      loudest = '0;
      return r;
    end
    if (turn_over) begin
      r.talk_started = spoke;
      r.peak_mean = loudest;
      r.ignored = 1'b1;
      return r;
    end
    take = (it.block_samples > BLOCK_LIMIT) ? 24'(BLOCK_LIMIT) : 24'(it.block_samples);
    room = (recorded < total_cfg) ? total_cfg - recorded : '0;
    if (take > room) take = room;
    // never passes the larger of total_cfg and recorded, so 24 bits hold it
    filled = recorded + take;
    if (it.block_mean > loudest) loudest = it.block_mean;
    if (it.cloud_voice && !spoke) begin
      spoke = 1'b1;
      quiet = 1'b0;
      quiet_since = '0;
    end
    if (filled >= total_cfg) begin
      r.is_last = 1'b1;
      r.end_reason = REASON_ALL_SAMPLES;
    end
    if (it.block_mean > thr_cfg) begin
      r.loud = 1'b1;
      if (!onset_seen) begin
        onset_seen = 1'b1;
        r.voice_onset = 1'b1;
      end
      spoke = 1'b1;
      quiet = 1'b0;
      quiet_since = '0;
    end else if (!quiet) begin
      quiet = 1'b1;
      quiet_since = it.now_ms;
    end else if (spoke) begin
      // silence length wraps with the millisecond clock
      quiet_ms = it.now_ms - quiet_since;
      if (quiet_ms >= {16'b0, silence_cfg}) begin
        r.is_last = 1'b1;
        if (r.end_reason == REASON_NONE) r.end_reason = REASON_SILENCE;
      end
    end else if (filled >= start_cfg) begin
      r.is_last = 1'b1;
      if (r.end_reason == REASON_NONE) r.end_reason = REASON_NO_SPEECH;
    end
    recorded = filled;
    if (r.is_last) turn_over = 1'b1;
    r.talk_started = spoke;
    r.peak_mean = loudest;
    return r;
  endfunction

  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic step_t blk(action_t act, logic [15:0] mean, logic [10:0] smp,
                                logic [31:0] now, logic cloud, bit lit = 1'b0,
                                sed_result_t want = '0);
    step_t s;
    s.is_cfg = 1'b0;
    s.idx = REG_THRESHOLD;
    s.val = '0;
    s.it.action = act;
    s.it.block_mean = mean;
    s.it.block_samples = smp;
    s.it.now_ms = now;
    s.it.cloud_voice = cloud;
    s.lit = lit;
    s.want = want;
    return s;
  endfunction

  function automatic step_t reg_row(reg_idx_t idx, logic [23:0] val);
    step_t s;
    s = blk(ACT_START, '0, '0, '0, 1'b0);
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
             what, results_seen, got, want);
    mismatches++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THRESHOLD:     thr_cfg = val[15:0];
      REG_SILENCE_LIMIT: silence_cfg = val[15:0];
      REG_START_TIMEOUT: start_cfg = val;
      REG_TOTAL_SAMPLES: total_cfg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait for every outstanding result before touching the registers
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_item(input sed_item_t it, input bit lit, input sed_result_t want,
                           input bit hurry);
    int gap;
    sed_result_t r;
    gap = hurry ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.action;
    in_tdata <= {4'b0, it.cloud_voice, it.now_ms, it.block_samples, it.block_mean};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_endpoint(it);
    pending_results.push_back(lit ? want : r);
  endtask

  // result side: random stalls, one long hold-off on request, field checks
  always @(posedge clk) begin : sink
    sed_out_data_t got;
    sed_result_t   want;
    int            stall_left;
    int            g;
    bit            snk_burst;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      snk_burst = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item", out_tdata, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_tlast !== want.is_last) report_mismatch("is_last", out_tlast, want.is_last);
          if (got.end_reason !== want.end_reason)
            report_mismatch("end_reason", got.end_reason, want.end_reason);
          if (got.loud !== want.loud) report_mismatch("loud", got.loud, want.loud);
          if (got.talk_started !== want.talk_started)
            report_mismatch("talk_started", got.talk_started, want.talk_started);
          if (got.voice_onset !== want.voice_onset)
            report_mismatch("voice_onset", got.voice_onset, want.voice_onset);
          if (got.peak_mean !== want.peak_mean)
            report_mismatch("peak_mean", got.peak_mean, want.peak_mean);
          if (got.ignored !== want.ignored)
            report_mismatch("ignored", got.ignored, want.ignored);
        end
        results_seen++;
      end
      if ($urandom_range(0, 127) == 0) snk_burst = !snk_burst;
      if (hold_served != hold_asked) begin
        hold_served++;
        stall_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        g = snk_burst ? 0 : pick_gap();
        out_tready <= (g == 0);
        stall_left = (g > 0) ? g - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    sed_item_t it;
    bit        src_burst;
    bit        voiced;
    bit [31:0] clock_ms;
    int        r;
    src_burst = 1'b0;
    voiced = 1'b0;
    clock_ms = '0;

    // reset defaults, long silence ending a turn across the clock wrap
    plan.push_back(blk(ACT_START, 16'd0, 11'd0, 32'd0, 1'b0, 1'b1, '0));
    plan.push_back(blk(ACT_BLOCK, 16'd0, 11'd0, 32'd0, 1'b0, 1'b1, '0));
    plan.push_back(blk(ACT_BLOCK, 16'd32768, 11'd2047, 32'hFFFF_FFFF, 1'b1, 1'b1,
                       '{1'b0, REASON_NONE, 1'b1, 1'b1, 1'b1, 16'd32768, 1'b0}));
    plan.push_back(blk(ACT_BLOCK, 16'd1000, 11'd1024, 32'hFFFF_FF00, 1'b0));
    plan.push_back(blk(ACT_BLOCK, 16'd999, 11'd1024, 32'h0000_02E7, 1'b0));
    plan.push_back(blk(ACT_BLOCK, 16'd1, 11'd1, 32'h0000_02E8, 1'b0));
    plan.push_back(blk(ACT_BLOCK, 16'd32768, 11'd1024, 32'd5, 1'b1, 1'b1,
                       '{1'b0, REASON_NONE, 1'b0, 1'b1, 1'b0, 16'd32768, 1'b1}));
    // recognizer text starts speech, onset comes later
    plan.push_back(blk(ACT_START, 16'd0, 11'd0, 32'd0, 1'b0, 1'b1, '0));
    plan.push_back(blk(ACT_BLOCK, 16'd0, 11'd512, 32'd100, 1'b1));
    plan.push_back(blk(ACT_BLOCK, 16'd1001, 11'd512, 32'd1100, 1'b0));
    // no speech before the start timeout
    plan.push_back(reg_row(REG_START_TIMEOUT, 24'd2000));
    plan.push_back(reg_row(REG_TOTAL_SAMPLES, 24'hFF_FFFF));
    plan.push_back(blk(ACT_START, 16'd0, 11'd0, 32'd0, 1'b0, 1'b1, '0));
    plan.push_back(blk(ACT_BLOCK, 16'd1000, 11'd1024, 32'd7, 1'b0));
    plan.push_back(blk(ACT_BLOCK, 16'd0, 11'd1024, 32'd7, 1'b0));
    // sample limit and timeout on the same block
    plan.push_back(reg_row(REG_TOTAL_SAMPLES, 24'd2048));
    plan.push_back(blk(ACT_START, 16'd0, 11'd0, 32'd0, 1'b0, 1'b1, '0));
    plan.push_back(blk(ACT_BLOCK, 16'd0, 11'd1500, 32'd0, 1'b0));
    plan.push_back(blk(ACT_BLOCK, 16'd0, 11'd1024, 32'd0, 1'b0));
    // zero limits
    plan.push_back(reg_row(REG_TOTAL_SAMPLES, 24'd1));
    plan.push_back(reg_row(REG_START_TIMEOUT, 24'd0));
    plan.push_back(reg_row(REG_SILENCE_LIMIT, 24'd0));
    plan.push_back(blk(ACT_START, 16'd0, 11'd0, 32'd0, 1'b0, 1'b1, '0));
    plan.push_back(blk(ACT_BLOCK, 16'd0, 11'd0, 32'd0, 1'b0));
    plan.push_back(blk(ACT_BLOCK, 16'd0, 11'd0, 32'd0, 1'b0));
    plan.push_back(blk(ACT_START, 16'd0, 11'd0, 32'd0, 1'b0, 1'b1, '0));
    plan.push_back(blk(ACT_BLOCK, 16'd2000, 11'd0, 32'd10, 1'b0));
    plan.push_back(blk(ACT_BLOCK, 16'd0, 11'd0, 32'd50, 1'b0));
    plan.push_back(blk(ACT_BLOCK, 16'd0, 11'd0, 32'd50, 1'b0));
    // total lowered below what is already recorded
    plan.push_back(reg_row(REG_TOTAL_SAMPLES, 24'hFF_FFFF));
    plan.push_back(reg_row(REG_THRESHOLD, 24'd0));
    plan.push_back(blk(ACT_START, 16'd0, 11'd0, 32'd0, 1'b0, 1'b1, '0));
    plan.push_back(blk(ACT_BLOCK, 16'd1, 11'd1024, 32'd0, 1'b0));
    plan.push_back(reg_row(REG_TOTAL_SAMPLES, 24'd512));
    plan.push_back(blk(ACT_BLOCK, 16'd0, 11'd100, 32'd3, 1'b0));
    // threshold and silence limit at their tops
    plan.push_back(reg_row(REG_THRESHOLD, 24'd32768));
    plan.push_back(reg_row(REG_SILENCE_LIMIT, 24'hFFFF));
    plan.push_back(reg_row(REG_TOTAL_SAMPLES, 24'hFF_FFFF));
    plan.push_back(blk(ACT_START, 16'd0, 11'd0, 32'd0, 1'b0, 1'b1, '0));
    plan.push_back(blk(ACT_BLOCK, 16'd32768, 11'd1024, 32'd0, 1'b0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        push_item(plan[i].it, plan[i].lit, plan[i].want, 1'b0);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      r = $urandom_range(0, 5);
      write_reg(REG_THRESHOLD, (r == 0) ? 24'd0 : (r == 1) ? 24'd32768 :
                24'($urandom_range(200, 20000)));
      r = $urandom_range(0, 5);
      write_reg(REG_SILENCE_LIMIT, (r == 0) ? 24'd0 : (r == 1) ? 24'hFFFF :
                24'($urandom_range(1, 400)));
      r = $urandom_range(0, 5);
      write_reg(REG_START_TIMEOUT, (r == 0) ? 24'd0 : (r == 1) ? 24'hFF_FFFF :
                24'($urandom_range(0, 12000)));
      r = $urandom_range(0, 5);
      write_reg(REG_TOTAL_SAMPLES, (r == 0) ? 24'd1 : (r == 1) ? 24'hFF_FFFF :
                24'($urandom_range(1, 30000)));
      // one phase runs back to back against a stalled receiver
      if (phase == 1) hold_asked++;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 63) == 0) src_burst = !src_burst;
        // mostly whole turns: start, blocks until the end, a few late blocks
        if (turn_over) it.action = ($urandom_range(0, 9) < 7) ? ACT_START : ACT_BLOCK;
        else it.action = ($urandom_range(0, 99) < 3) ? ACT_START : ACT_BLOCK;
        if ($urandom_range(0, 99) < 15) voiced = !voiced;
        r = $urandom_range(0, 99);
        if (r < 10) it.block_mean = 16'($urandom_range(0, 32768));
        else if (voiced && thr_cfg < 16'd32768)
          it.block_mean = 16'($urandom_range(thr_cfg + 1, 32768));
        else it.block_mean = 16'($urandom_range(0, thr_cfg));
        r = $urandom_range(0, 99);
        if (r < 70) it.block_samples = 11'd1024;
        else if (r < 92) it.block_samples = 11'($urandom_range(0, 1024));
        else it.block_samples = 11'($urandom_range(0, 2047));
        r = $urandom_range(0, 99);
        if (r < 3) clock_ms = $urandom;
        else if (r < 5) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
        else clock_ms += $urandom_range(0, silence_cfg / 2 + 40);
        it.now_ms = clock_ms;
        it.cloud_voice = ($urandom_range(0, 99) < 4);
        push_item(it, 1'b0, '0, src_burst || (phase == 1 && n < 120));
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
